// ===== hw/rtl/vgcs_pkg.sv =====
// Shared types and constants for the voxel grid count subdivider.
package vgcs_pkg;

    localparam int MAX_GRID_SIZE = 16;
    localparam int COUNT_BITS    = 24;
    localparam int STACK_DEPTH   = 16;
    localparam int COORD_BITS    = $clog2(MAX_GRID_SIZE);
    localparam int CELL_BITS     = 3 * COORD_BITS;
    localparam int LEVEL_BITS    = $clog2(STACK_DEPTH + 1);
    localparam int SP_BITS       = $clog2(STACK_DEPTH);
    localparam int SIZE_BITS     = 5;
    localparam int THRESH_BITS   = 36;
    localparam int SUM_BITS      = COUNT_BITS + CELL_BITS;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESH = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] lo_x, lo_y, lo_z;
        logic [COORD_BITS-1:0] hi_x, hi_y, hi_z;
    } t_box;

    typedef enum logic [2:0] {
        ST_IDLE, ST_POP, ST_SUM, ST_DECIDE, ST_OUT, ST_DONE
    } t_state;

    typedef struct packed {
        logic write_cell;
        logic start;
        logic pop;
        logic sum_start;
        logic split;
        logic emit_leaf;
        logic emit_done;
    } t_cmd;

    typedef struct packed {
        logic stack_empty;
        logic sum_busy;
        logic is_leaf;
    } t_status;

endpackage

// ===== hw/rtl/vgcs_ctrl.sv =====
// Controller state machine of the voxel grid count subdivider.
module vgcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_op,
    input  logic                i_out_free,
    input  vgcs_pkg::t_status   i_status,
    output logic                o_ready,
    output vgcs_pkg::t_cmd      o_cmd
);
    vgcs_pkg::t_state r_state, n_state;
    logic acc;

    assign acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= vgcs_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vgcs_pkg::ST_IDLE: begin
                if (acc && i_op == vgcs_pkg::OP_FETCH) n_state = vgcs_pkg::ST_POP;
            end
            vgcs_pkg::ST_POP: begin
                if (i_status.stack_empty) n_state = vgcs_pkg::ST_DONE;
                else                      n_state = vgcs_pkg::ST_SUM;
            end
            vgcs_pkg::ST_SUM: begin
                if (!i_status.sum_busy) n_state = vgcs_pkg::ST_DECIDE;
            end
            vgcs_pkg::ST_DECIDE: begin
                if (i_status.is_leaf) n_state = vgcs_pkg::ST_OUT;
                else                  n_state = vgcs_pkg::ST_POP;
            end
            vgcs_pkg::ST_OUT: begin
                if (i_out_free) n_state = vgcs_pkg::ST_IDLE;
            end
            vgcs_pkg::ST_DONE: begin
                if (i_out_free) n_state = vgcs_pkg::ST_IDLE;
            end
            default: n_state = vgcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            vgcs_pkg::ST_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.write_cell = acc && i_op == vgcs_pkg::OP_WRITE;
                o_cmd.start      = acc && i_op == vgcs_pkg::OP_START;
            end
            vgcs_pkg::ST_POP: begin
                o_cmd.pop       = !i_status.stack_empty;
                o_cmd.sum_start = !i_status.stack_empty;
            end
            vgcs_pkg::ST_SUM: ;
            vgcs_pkg::ST_DECIDE: begin
                o_cmd.split = !i_status.is_leaf;
            end
            vgcs_pkg::ST_OUT: begin
                o_cmd.emit_leaf = i_out_free;
            end
            vgcs_pkg::ST_DONE: begin
                o_cmd.emit_done = i_out_free;
            end
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/vgcs_datapath.sv =====
// Datapath: count grid memory, box stack, summing walker and split logic.
module vgcs_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  vgcs_pkg::t_cmd                       i_cmd,
    input  logic [vgcs_pkg::COORD_BITS-1:0]      i_cell_x,
    input  logic [vgcs_pkg::COORD_BITS-1:0]      i_cell_y,
    input  logic [vgcs_pkg::COORD_BITS-1:0]      i_cell_z,
    input  logic [vgcs_pkg::COUNT_BITS-1:0]      i_cell_count,
    input  logic [vgcs_pkg::SIZE_BITS-1:0]       i_size_x,
    input  logic [vgcs_pkg::SIZE_BITS-1:0]       i_size_y,
    input  logic [vgcs_pkg::SIZE_BITS-1:0]       i_size_z,
    input  logic [vgcs_pkg::THRESH_BITS-1:0]     i_thresh,
    output vgcs_pkg::t_status                    o_status,
    output vgcs_pkg::t_box                       o_box
);
    localparam int CB = vgcs_pkg::COORD_BITS;
    localparam int SB = vgcs_pkg::SIZE_BITS;

    logic [vgcs_pkg::COUNT_BITS-1:0] r_grid [0:(1 << vgcs_pkg::CELL_BITS)-1];
    vgcs_pkg::t_box r_stack [0:vgcs_pkg::STACK_DEPTH-1];
    logic [vgcs_pkg::LEVEL_BITS-1:0] r_level;
    vgcs_pkg::t_box r_box;
    logic [CB-1:0] r_x, r_y, r_z;
    logic r_walk, r_rd_vld, r_busy;
    logic [vgcs_pkg::COUNT_BITS-1:0] r_rd;
    logic [vgcs_pkg::SUM_BITS-1:0] r_sum;
    logic [SB-1:0] ex, ey, ez;
    logic in_grid, multi, last_cell;
    logic [CB-1:0] dx, dy, dz, dsel, half;
    logic [1:0] ax;
    vgcs_pkg::t_box lower, upper;
    logic [vgcs_pkg::LEVEL_BITS-1:0] lvl_top;

    function automatic logic [SB-1:0] eff(input logic [SB-1:0] s);
        if (s == '0) return SB'(1);
        if (s > SB'(vgcs_pkg::MAX_GRID_SIZE)) return SB'(vgcs_pkg::MAX_GRID_SIZE);
        return s;
    endfunction

    assign ex = eff(i_size_x);
    assign ey = eff(i_size_y);
    assign ez = eff(i_size_z);
    assign in_grid = SB'(i_cell_x) < ex && SB'(i_cell_y) < ey && SB'(i_cell_z) < ez;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_cell && in_grid) r_grid[{i_cell_z, i_cell_y, i_cell_x}] <= i_cell_count;
        r_rd <= r_grid[{r_z, r_y, r_x}];
    end

    assign dx = r_box.hi_x - r_box.lo_x;
    assign dy = r_box.hi_y - r_box.lo_y;
    assign dz = r_box.hi_z - r_box.lo_z;
    assign multi = (dx | dy | dz) != '0;
    assign last_cell = r_x == r_box.hi_x && r_y == r_box.hi_y && r_z == r_box.hi_z;

    // Walk z fastest, then y, then x; read data is registered and arrives in the cycle after its address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= 1'b0; r_rd_vld <= 1'b0; r_busy <= 1'b0;
        end else begin
            r_rd_vld <= r_walk;
            if (i_cmd.sum_start) begin
                r_busy <= 1'b1;
                r_walk <= 1'b1;
            end else if (r_walk) begin
                if (last_cell) r_walk <= 1'b0;
            end else if (!r_rd_vld) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_start) begin
            r_sum <= '0;
            r_x <= r_stack[lvl_top[vgcs_pkg::SP_BITS-1:0]].lo_x;
            r_y <= r_stack[lvl_top[vgcs_pkg::SP_BITS-1:0]].lo_y;
            r_z <= r_stack[lvl_top[vgcs_pkg::SP_BITS-1:0]].lo_z;
        end else begin
            if (r_rd_vld) r_sum <= r_sum + vgcs_pkg::SUM_BITS'(r_rd);
            if (r_walk && !last_cell) begin
                if (r_z != r_box.hi_z) r_z <= r_z + 1'b1;
                else begin
                    r_z <= r_box.lo_z;
                    if (r_y != r_box.hi_y) r_y <= r_y + 1'b1;
                    else begin
                        r_y <= r_box.lo_y;
                        r_x <= r_x + 1'b1;
                    end
                end
            end
        end
    end

    assign lvl_top = r_level - 1'b1;

    always_comb begin
        if (dx != '0 && dx >= dy && dx >= dz) ax = 2'd0;
        else if (dy != '0 && dy >= dz)        ax = 2'd1;
        else                                  ax = 2'd2;
        case (ax)
            2'd0:    dsel = dx;
            2'd1:    dsel = dy;
            default: dsel = dz;
        endcase
        half  = dsel >> 1;
        lower = r_box;
        upper = r_box;
        case (ax)
            2'd0: begin
                lower.hi_x = r_box.lo_x + half; upper.lo_x = r_box.lo_x + half + 1'b1;
            end
            2'd1: begin
                lower.hi_y = r_box.lo_y + half; upper.lo_y = r_box.lo_y + half + 1'b1;
            end
            default: begin
                lower.hi_z = r_box.lo_z + half; upper.lo_z = r_box.lo_z + half + 1'b1;
            end
        endcase
    end

    // The split pushes both boxes in the same cycle, dropping any beyond the depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cmd.start) begin
            r_level <= vgcs_pkg::LEVEL_BITS'(1);
        end else if (i_cmd.pop) begin
            r_level <= lvl_top;
        end else if (i_cmd.split) begin
            if (r_level < vgcs_pkg::LEVEL_BITS'(vgcs_pkg::STACK_DEPTH - 1))
                r_level <= r_level + vgcs_pkg::LEVEL_BITS'(2);
            else if (r_level < vgcs_pkg::LEVEL_BITS'(vgcs_pkg::STACK_DEPTH))
                r_level <= r_level + vgcs_pkg::LEVEL_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_stack[0] <= '{lo_x: '0, lo_y: '0, lo_z: '0,
                            hi_x: CB'(ex - 1'b1), hi_y: CB'(ey - 1'b1), hi_z: CB'(ez - 1'b1)};
        end else if (i_cmd.split) begin
            if (r_level < vgcs_pkg::LEVEL_BITS'(vgcs_pkg::STACK_DEPTH))
                r_stack[r_level[vgcs_pkg::SP_BITS-1:0]] <= lower;
            if (r_level < vgcs_pkg::LEVEL_BITS'(vgcs_pkg::STACK_DEPTH - 1))
                r_stack[r_level[vgcs_pkg::SP_BITS-1:0] + 1'b1] <= upper;
        end
        if (i_cmd.pop) r_box <= r_stack[lvl_top[vgcs_pkg::SP_BITS-1:0]];
    end

    assign o_status.stack_empty = r_level == '0;
    assign o_status.sum_busy    = r_busy;
    assign o_status.is_leaf     = !multi || vgcs_pkg::THRESH_BITS'(r_sum) < i_thresh;
    assign o_box = r_box;
endmodule

// ===== hw/rtl/voxel_grid_count_subdivider.sv =====
// Top level of the voxel grid count subdivider.
// A fetch pops boxes, sums the counts in each and splits each non-leaf box until a
// leaf is popped and emitted; on an empty stack it emits the done item instead.
// Flow: one item at a time; input is ready only while the controller is idle.
// Reset: synchronous active low; clears stack level, walker, controller and output valid.
// Registers reset to sizes 16, 16, 16 and threshold 1048576.
module voxel_grid_count_subdivider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], cell_x[5:2], cell_y[9:6], cell_z[13:10], cell_count[37:14], zeros
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // low_x, low_y, low_z, high_x, high_y, high_z (4 bits each from bit 0); zeros on a done item
    output logic [23:0] m_axis_tdata,
    // plan_done
    output logic        m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [35:0] i_cfg_data
);
    logic [vgcs_pkg::SIZE_BITS-1:0] r_size_x, r_size_y, r_size_z;
    logic [vgcs_pkg::THRESH_BITS-1:0] r_thresh;
    vgcs_pkg::t_cmd cmd;
    vgcs_pkg::t_status status;
    vgcs_pkg::t_box box;
    logic out_free;
    logic r_ovld, r_done;
    logic [23:0] r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 5'd16; r_size_y <= 5'd16; r_size_z <= 5'd16;
            r_thresh <= 36'd1048576;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vgcs_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data[4:0];
                vgcs_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data[4:0];
                vgcs_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data[4:0];
                vgcs_pkg::CFG_THRESH: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !r_ovld || m_axis_tready;

    vgcs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .i_op(s_axis_tdata[1:0]),
        .i_out_free(out_free), .i_status(status),
        .o_ready(s_axis_tready), .o_cmd(cmd)
    );

    vgcs_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_cell_x(s_axis_tdata[5:2]), .i_cell_y(s_axis_tdata[9:6]),
        .i_cell_z(s_axis_tdata[13:10]), .i_cell_count(s_axis_tdata[37:14]),
        .i_size_x(r_size_x), .i_size_y(r_size_y), .i_size_z(r_size_z),
        .i_thresh(r_thresh), .o_status(status), .o_box(box)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (cmd.emit_leaf || cmd.emit_done) begin
            r_ovld <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit_leaf) begin
            r_odata <= {box.hi_z, box.hi_y, box.hi_x, box.lo_z, box.lo_y, box.lo_x};
            r_done  <= 1'b0;
        end else if (cmd.emit_done) begin
            r_odata <= '0;
            r_done  <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_done;

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("done item carries a box");
    a_no_dual_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.emit_leaf && cmd.emit_done))
        else $error("leaf and done emitted together");
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_leaf || cmd.emit_done |=> m_axis_tvalid)
        else $error("emitted item not shown");
endmodule
